// ===== rtl/wrra_pkg.sv =====
// shared types and constants for the weighted round-robin arbiter
`timescale 1ns / 1ps
package wrra_pkg;

    // width of one credit counter and one reload weight
    localparam int CREDIT_W = 4;
    localparam int WEIGHT_W = 4;

    // number of weight fields held in the weight register
    localparam int WEIGHT_FIELDS = 8;
    localparam int WEIGHTS_W = WEIGHT_FIELDS * WEIGHT_W;

    // reset value of the weight register: slot 0 weight 1, others weight 2
    localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 32'h2222_2221;

    // width of the reported slot index
    localparam int SLOT_FIELD_W = 3;

    // input mask width
    localparam int MASK_W = 8;

    typedef logic [CREDIT_W-1:0] t_credit;
    typedef logic [WEIGHT_W-1:0] t_weight;

    // per-lane control from the merge stage
    typedef struct packed {
        logic req;
        logic win;
        logic ahead;
    } t_lane_ctl;

endpackage

// ===== rtl/wrra_lane.sv =====
// one slot lane: candidate check and credit update
`timescale 1ns / 1ps
module wrra_lane (
    input  wrra_pkg::t_credit   i_credit,
    input  wrra_pkg::t_weight   i_weight,
    input  wrra_pkg::t_credit   i_min,
    input  wrra_pkg::t_lane_ctl i_ctl,
    output logic                o_cand,
    output wrra_pkg::t_credit   o_next_credit
);
    import wrra_pkg::*;

    t_credit reload;

    // a weight of zero reloads as one
    assign reload = (i_weight == '0) ? t_credit'(1) : t_credit'(i_weight);

    // requesting slot holding the lowest credit can win
    assign o_cand = i_ctl.req && (i_credit == i_min);

    // slots walked before the winner lose one extra credit
    always_comb begin
        if (!i_ctl.req) begin
            o_next_credit = i_credit;
        end else if (i_ctl.win) begin
            o_next_credit = reload;
        end else begin
            o_next_credit = i_credit - i_min - t_credit'(i_ctl.ahead);
        end
    end

endmodule

// ===== rtl/wrra_merge.sv =====
// merge stage: lowest credit over lanes and round-robin winner pick
`timescale 1ns / 1ps
module wrra_merge #(
    parameter int SLOTS = 8
) (
    input  wrra_pkg::t_credit                 i_credit [SLOTS],
    input  logic [SLOTS-1:0]                  i_req,
    input  logic [SLOTS-1:0]                  i_cand,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_last,
    output wrra_pkg::t_credit                 o_min,
    output logic                              o_any,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_win,
    output logic [SLOTS-1:0]                  o_before
);
    import wrra_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;

    t_credit           tree [NODES];
    logic [SLOTS-1:0]  after_last;
    logic [SLOTS-1:0]  hi_cand;
    logic [IDX_W-1:0]  hi_idx;
    logic [IDX_W-1:0]  lo_idx;

    // min tree leaves: idle lanes read as full credit
    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < SLOTS) begin : g_real
            assign tree[LEAVES-1+g] = i_req[g] ? i_credit[g] : '1;
        end else begin : g_pad
            assign tree[LEAVES-1+g] = '1;
        end
    end

    // min tree inner nodes
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        assign tree[n] = (tree[2*n+1] <= tree[2*n+2]) ? tree[2*n+1] : tree[2*n+2];
    end

    assign o_min = tree[0];

    // slots later than the last winner in index order
    for (genvar g = 0; g < SLOTS; g++) begin : g_after
        assign after_last[g] = (IDX_W'(g) > i_last);
    end

    assign hi_cand = i_cand & after_last;
    assign o_any   = |i_cand;

    // lowest-index candidate, both over later slots and over all slots
    always_comb begin
        hi_idx = '0;
        lo_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hi_cand[i]) begin
                hi_idx = IDX_W'(i);
            end
            if (i_cand[i]) begin
                lo_idx = IDX_W'(i);
            end
        end
    end

    assign o_win = (|hi_cand) ? hi_idx : lo_idx;

    // slots the walk visits ahead of the winner in its last pass
    for (genvar g = 0; g < SLOTS; g++) begin : g_before
        assign o_before[g] = (o_win > i_last) ? (after_last[g] && (IDX_W'(g) < o_win))
                                              : (after_last[g] || (IDX_W'(g) < o_win));
    end

endmodule

// ===== rtl/weighted_round_robin_arbiter_unit.sv =====
// weighted round-robin arbiter top level: lanes, merge stage, sequencer
// each request passes in turn through capture, lowest credit over the lane
// min tree, winner pick and credit update
// a result becomes valid once the update step completes; the update step
// waits while a previous result is still stalled in the output register
// synchronous active-low reset clears all credits and the last winner and loads default weights
`timescale 1ns / 1ps
module weighted_round_robin_arbiter_unit #(
    parameter int SLOTS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [wrra_pkg::MASK_W-1:0]             i_request_mask,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic                                    o_granted,
    output logic [wrra_pkg::SLOT_FIELD_W-1:0]       o_winner_slot,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [wrra_pkg::WEIGHTS_W-1:0]          i_cfg_data
);
    import wrra_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIN  = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [WEIGHTS_W-1:0]    r_weights;
    t_credit                 r_credit [SLOTS];
    logic [IDX_W-1:0]        r_last;
    logic [SLOTS-1:0]        r_mask;
    t_credit                 r_min;
    logic                    r_any;
    logic [IDX_W-1:0]        r_win;
    logic [SLOTS-1:0]        r_before;
    logic                    r_out_valid;
    logic                    r_granted;
    logic [SLOT_FIELD_W-1:0] r_slot;

    t_weight                 weight     [SLOTS];
    t_lane_ctl               lane_ctl   [SLOTS];
    t_credit                 next_credit [SLOTS];
    logic [SLOTS-1:0]        cand;
    t_credit                 merge_min;
    logic                    merge_any;
    logic [IDX_W-1:0]        merge_win;
    logic [SLOTS-1:0]        merge_before;
    logic                    in_take;
    logic                    upd_go;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign upd_go      = (r_state == ST_UPD) && (!r_out_valid || !i_out_stall);

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_winner_slot = r_slot;

    // weight field per slot; slots past the register read as zero
    for (genvar g = 0; g < SLOTS; g++) begin : g_weight
        if (g < WEIGHT_FIELDS) begin : g_field
            assign weight[g] = r_weights[g*WEIGHT_W +: WEIGHT_W];
        end else begin : g_none
            assign weight[g] = '0;
        end
    end

    // slot lanes
    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        assign lane_ctl[g].req   = r_mask[g];
        assign lane_ctl[g].win   = r_any && (r_win == IDX_W'(g));
        assign lane_ctl[g].ahead = r_before[g];

        wrra_lane u_lane (
            .i_credit      (r_credit[g]),
            .i_weight      (weight[g]),
            .i_min         (r_min),
            .i_ctl         (lane_ctl[g]),
            .o_cand        (cand[g]),
            .o_next_credit (next_credit[g])
        );
    end

    // merge of lane results
    wrra_merge #(
        .SLOTS (SLOTS)
    ) u_merge (
        .i_credit (r_credit),
        .i_req    (r_mask),
        .i_cand   (cand),
        .i_last   (r_last),
        .o_min    (merge_min),
        .o_any    (merge_any),
        .o_win    (merge_win),
        .o_before (merge_before)
    );

    // sequencer next state
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = in_take ? ST_MIN : ST_IDLE;
            ST_MIN:  n_state = ST_PICK;
            ST_PICK: n_state = ST_UPD;
            ST_UPD:  n_state = upd_go ? ST_IDLE : ST_UPD;
            default: n_state = ST_IDLE;
        endcase
    end

    // control state, weights and credits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_weights   <= WEIGHTS_RESET;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_credit[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_weights <= i_cfg_data;
            end
            if (upd_go) begin
                r_out_valid <= 1'b1;
                if (r_any) begin
                    r_last <= r_win;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_credit[i] <= next_credit[i];
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers of the request in flight and the result
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mask <= SLOTS'(i_request_mask);
        end
        if (r_state == ST_MIN) begin
            r_min <= merge_min;
        end
        if (r_state == ST_PICK) begin
            r_any    <= merge_any;
            r_win    <= merge_win;
            r_before <= merge_before;
        end
        if (upd_go) begin
            r_granted <= r_any;
            r_slot    <= r_any ? SLOT_FIELD_W'(r_win) : '0;
        end
    end

`ifndef SYNTH
    // a nonempty mask always leaves a candidate at the lowest credit
    a_cand_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) && (r_mask != '0) |-> (cand != '0))
        else $error("no candidate for nonempty request");

    // the winner is a requesting slot
    a_win_requested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) && r_any |-> r_mask[r_win])
        else $error("winner not requested");

    // the winner's credit is reloaded nonzero
    a_reload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go && r_any |=> (r_credit[r_last] != '0))
        else $error("winner credit not reloaded");

    // a result without a grant reports slot zero
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_granted |-> (o_winner_slot == '0))
        else $error("slot set without grant");
`endif

endmodule
